@@ hw/rtl/sorted_software_timer_queue_macros.svh @@
// Assertion macros for the sorted timer queue checker.
`ifndef SORTED_SOFTWARE_TIMER_QUEUE_MACROS_SVH
`define SORTED_SOFTWARE_TIMER_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define STQ_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define STQ_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/stq_pkg.sv @@
// Shared types and constants of the sorted timer queue.
`default_nettype none
package stq_pkg;

  localparam int CAPACITY_DEF  = 16;
  localparam int TICK_BITS_DEF = 32;
  localparam int MAX_RESULTS   = 16;
  localparam int DRAIN_W       = $clog2(MAX_RESULTS);
  localparam int DELAY_W       = 32;
  localparam int ID_W          = 32;
  localparam int TAG_W         = 8;
  localparam int DL_OUT_W      = 32;

  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_REJECT = 2'd1,
    KIND_EXPIRE = 2'd2
  } kind_e;

  typedef struct packed {
    logic capture;
    logic tick_inc;
    logic arm_commit;
    logic drain_clear;
    logic drain_pop;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic head_due;
    logic pop_last;
  } status_t;

endpackage
`default_nettype wire

@@ hw/rtl/stq_ctrl.sv @@
// Controller state machine of the sorted timer queue.
`default_nettype none
module stq_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  input  wire              mode_i,
  output logic             in_ready_o,
  input  stq_pkg::status_t status_i,
  output stq_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ARM   = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (mode_i) begin
            cmd_o.tick_inc    = 1'b1;
            cmd_o.drain_clear = 1'b1;
            state_d           = ST_DRAIN;
          end else begin
            state_d = ST_ARM;
          end
        end
      end
      ST_ARM: begin
        if (status_i.out_free) begin
          cmd_o.arm_commit = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_DRAIN: begin
        if (!status_i.head_due) begin
          state_d = ST_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.drain_pop = 1'b1;
          if (status_i.pop_last) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

endmodule
`default_nettype wire

@@ hw/rtl/stq_datapath.sv @@
// Datapath of the sorted timer queue: tick counter, sorted entry cells, result register.
`default_nettype none
module stq_datapath #(
  parameter int CAPACITY  = stq_pkg::CAPACITY_DEF,
  parameter int TICK_BITS = stq_pkg::TICK_BITS_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire [stq_pkg::DELAY_W-1:0]   delay_i,
  input  wire [stq_pkg::ID_W-1:0]      timer_ident_i,
  input  wire [stq_pkg::TAG_W-1:0]     handler_tag_i,
  input  stq_pkg::cmd_t                cmd_i,
  output stq_pkg::status_t             status_o,
  input  wire                          out_ready_i,
  output logic                         out_valid_o,
  output logic [1:0]                   kind_o,
  output logic [stq_pkg::ID_W-1:0]     expired_ident_o,
  output logic [stq_pkg::DL_OUT_W-1:0] deadline_o,
  output logic [stq_pkg::TAG_W-1:0]    callback_tag_o,
  output logic                         has_callback_o,
  output logic                         last_o
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = (TICK_BITS > stq_pkg::DELAY_W) ? TICK_BITS : stq_pkg::DELAY_W;

  logic [TICK_BITS-1:0]        tick_q;
  logic [TICK_BITS-1:0]        arm_dl_q;
  logic [stq_pkg::ID_W-1:0]    arm_id_q;
  logic [stq_pkg::TAG_W-1:0]   arm_tag_q;
  logic [TICK_BITS-1:0]        ent_dl_q  [CAPACITY];
  logic [stq_pkg::ID_W-1:0]    ent_id_q  [CAPACITY];
  logic [stq_pkg::TAG_W-1:0]   ent_tag_q [CAPACITY];
  logic [CNT_W-1:0]            cnt_q;
  logic [stq_pkg::DRAIN_W-1:0] drn_q;

  logic                        out_valid_q;
  stq_pkg::kind_e              out_kind_q;
  logic [stq_pkg::ID_W-1:0]    out_id_q;
  logic [TICK_BITS-1:0]        out_dl_q;
  logic [stq_pkg::TAG_W-1:0]   out_tag_q;
  logic                        out_last_q;

  logic [SUM_W-1:0]    sum;
  logic [CAPACITY-1:0] gt;
  logic [CAPACITY-1:0] gt_prev;
  logic                full;
  logic                insert;
  logic                next_due;

  assign sum     = SUM_W'(tick_q) + SUM_W'(delay_i);
  assign full    = (cnt_q == CNT_W'(CAPACITY));
  assign insert  = cmd_i.arm_commit && !full;
  assign gt_prev = {gt[CAPACITY-2:0], 1'b0};

  // gt: entry sorts after the pending arm (or is empty); a suffix of the table
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [TICK_BITS-1:0]      prev_dl, next_dl;
    logic [stq_pkg::ID_W-1:0]  prev_id, next_id;
    logic [stq_pkg::TAG_W-1:0] prev_tag, next_tag;

    assign gt[g] = !((CNT_W'(g) < cnt_q) && (ent_dl_q[g] <= arm_dl_q));

    if (g == 0) begin : g_first
      assign prev_dl  = arm_dl_q;
      assign prev_id  = arm_id_q;
      assign prev_tag = arm_tag_q;
    end else begin : g_mid
      assign prev_dl  = ent_dl_q[g-1];
      assign prev_id  = ent_id_q[g-1];
      assign prev_tag = ent_tag_q[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign next_dl  = ent_dl_q[g];
      assign next_id  = ent_id_q[g];
      assign next_tag = ent_tag_q[g];
    end else begin : g_body
      assign next_dl  = ent_dl_q[g+1];
      assign next_id  = ent_id_q[g+1];
      assign next_tag = ent_tag_q[g+1];
    end

    always_ff @(posedge clk_i) begin
      if (insert && gt[g]) begin
        if (!gt_prev[g]) begin
          ent_dl_q[g]  <= arm_dl_q;
          ent_id_q[g]  <= arm_id_q;
          ent_tag_q[g] <= arm_tag_q;
        end else begin
          ent_dl_q[g]  <= prev_dl;
          ent_id_q[g]  <= prev_id;
          ent_tag_q[g] <= prev_tag;
        end
      end else if (cmd_i.drain_pop) begin
        ent_dl_q[g]  <= next_dl;
        ent_id_q[g]  <= next_id;
        ent_tag_q[g] <= next_tag;
      end
    end
  end

  assign next_due          = (cnt_q > CNT_W'(1)) && (ent_dl_q[1] <= tick_q);
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign status_o.head_due = (cnt_q != '0) && (ent_dl_q[0] <= tick_q);
  assign status_o.pop_last = !next_due ||
                             (drn_q == stq_pkg::DRAIN_W'(stq_pkg::MAX_RESULTS - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      arm_dl_q  <= sum[TICK_BITS-1:0];
      arm_id_q  <= timer_ident_i;
      arm_tag_q <= handler_tag_i;
    end
    if (cmd_i.drain_clear)    drn_q <= '0;
    else if (cmd_i.drain_pop) drn_q <= drn_q + stq_pkg::DRAIN_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.tick_inc) tick_q <= tick_q + TICK_BITS'(1);
      if (insert)               cnt_q <= cnt_q + CNT_W'(1);
      else if (cmd_i.drain_pop) cnt_q <= cnt_q - CNT_W'(1);
      if (cmd_i.arm_commit || cmd_i.drain_pop) out_valid_q <= 1'b1;
      else if (out_ready_i)                    out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.arm_commit) begin
      out_kind_q <= full ? stq_pkg::KIND_REJECT : stq_pkg::KIND_ACCEPT;
      out_id_q   <= arm_id_q;
      out_dl_q   <= arm_dl_q;
      out_tag_q  <= arm_tag_q;
      out_last_q <= 1'b1;
    end else if (cmd_i.drain_pop) begin
      out_kind_q <= stq_pkg::KIND_EXPIRE;
      out_id_q   <= ent_id_q[0];
      out_dl_q   <= ent_dl_q[0];
      out_tag_q  <= ent_tag_q[0];
      out_last_q <= status_o.pop_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = out_kind_q;
  assign expired_ident_o = out_id_q;
  assign deadline_o      = stq_pkg::DL_OUT_W'(out_dl_q);
  assign callback_tag_o  = out_tag_q;
  assign has_callback_o  = (out_tag_q != '0);
  assign last_o          = out_last_q;

endmodule
`default_nettype wire

@@ hw/rtl/sorted_software_timer_queue.sv @@
// Top level of the sorted timer queue: controller plus datapath.
//
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_ready_o | mode, delay, timer_ident, handler_tag
//  out     | output    | out_valid_o/out_ready_i | kind, expired_ident, deadline, callback_tag,
//          |           |                         | has_callback, last
//
// Arm: accept, then insert; the insert compares all entry cells in parallel.
// Tick: accept, then a pop per expired entry up to MAX_RESULTS; one pop a cycle while out is free.
// One item at a time; in_ready_o is high only while the controller is idle.
// A full result register stalls the insert or pop until out_ready_i takes it.
// Reset clears the tick counter, entry count and result valid; no clearing pass.
`default_nettype none
module sorted_software_timer_queue #(
  parameter int CAPACITY  = stq_pkg::CAPACITY_DEF,
  parameter int TICK_BITS = stq_pkg::TICK_BITS_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire                          mode_i,
  input  wire [stq_pkg::DELAY_W-1:0]   delay_i,
  input  wire [stq_pkg::ID_W-1:0]      timer_ident_i,
  input  wire [stq_pkg::TAG_W-1:0]     handler_tag_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [1:0]                   kind_o,
  output logic [stq_pkg::ID_W-1:0]     expired_ident_o,
  output logic [stq_pkg::DL_OUT_W-1:0] deadline_o,
  output logic [stq_pkg::TAG_W-1:0]    callback_tag_o,
  output logic                         has_callback_o,
  output logic                         last_o
);

  stq_pkg::cmd_t    cmd;
  stq_pkg::status_t status;

  stq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  stq_datapath #(
    .CAPACITY  (CAPACITY),
    .TICK_BITS (TICK_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .delay_i         (delay_i),
    .timer_ident_i   (timer_ident_i),
    .handler_tag_i   (handler_tag_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .kind_o          (kind_o),
    .expired_ident_o (expired_ident_o),
    .deadline_o      (deadline_o),
    .callback_tag_o  (callback_tag_o),
    .has_callback_o  (has_callback_o),
    .last_o          (last_o)
  );

endmodule
`default_nettype wire

@@ hw/rtl/stq_checker.sv @@
// Port-level assertion checker for the sorted timer queue, with its bind.
`default_nettype none
`include "sorted_software_timer_queue_macros.svh"
module stq_checker (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          in_valid_i,
  input wire                          in_ready_o,
  input wire                          out_valid_o,
  input wire                          out_ready_i,
  input wire [1:0]                    kind_o,
  input wire [stq_pkg::ID_W-1:0]      expired_ident_o,
  input wire [stq_pkg::DL_OUT_W-1:0]  deadline_o,
  input wire [stq_pkg::TAG_W-1:0]     callback_tag_o,
  input wire                          has_callback_o,
  input wire                          last_o
);

  `STQ_ASSERT_NOW(a_arm_last, out_valid_o && (kind_o != stq_pkg::KIND_EXPIRE), last_o, "arm result without last")
  `STQ_ASSERT_NOW(a_kind_legal, out_valid_o, (kind_o == stq_pkg::KIND_ACCEPT) || (kind_o == stq_pkg::KIND_REJECT) || (kind_o == stq_pkg::KIND_EXPIRE), "illegal result kind")
  `STQ_ASSERT_NOW(a_cb_flag, out_valid_o, has_callback_o == (callback_tag_o != '0), "callback flag mismatch")
  `STQ_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready right after accept")
  `STQ_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(expired_ident_o) && $stable(deadline_o) && $stable(kind_o) && $stable(last_o), "stalled result changed")

endmodule

bind sorted_software_timer_queue stq_checker u_stq_checker (.*);
`default_nettype wire
